>>> sv/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types, constants and the SGR code decoder for the color parser.
// ----------------------------------------------------------------------------
package sgr_pkg;

   localparam int unsigned MAX_CODES = 8;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_ESC   = 2'd1;
   localparam logic [1:0] PH_PARAM = 2'd2;

   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [3:0] FG_DEFAULT = 4'd7;
   localparam logic [3:0] BG_DEFAULT = 4'd0;
   localparam logic [7:0] COLOR_RESET = 8'h07;

   localparam logic [7:0] SGR_RESET     = 8'd0;
   localparam logic [7:0] SGR_BOLD      = 8'd1;
   localparam logic [7:0] SGR_NOBOLD    = 8'd22;
   localparam logic [7:0] SGR_FG_LO     = 8'd30;
   localparam logic [7:0] SGR_FG_HI     = 8'd37;
   localparam logic [7:0] SGR_FG_DEF    = 8'd39;
   localparam logic [7:0] SGR_BG_LO     = 8'd40;
   localparam logic [7:0] SGR_BG_HI     = 8'd47;
   localparam logic [7:0] SGR_BG_DEF    = 8'd49;
   localparam logic [7:0] SGR_FGB_LO    = 8'd90;
   localparam logic [7:0] SGR_FGB_HI    = 8'd97;
   localparam logic [7:0] SGR_BGB_LO    = 8'd100;
   localparam logic [7:0] SGR_BGB_HI    = 8'd107;

   typedef struct packed {
      logic [3:0] fg;
      logic [3:0] bg;
      logic       bold;
      logic       touched;
   } shadow_type;

   typedef struct packed {
      logic [1:0] phase;
      logic [7:0] num;
      logic       present;
      logic [3:0] count;
      shadow_type sh;
      logic [7:0] color;
      logic       bold;
   } parse_state_type;

   typedef struct packed {
      logic       consumed;
      logic       applied;
      logic       aborted;
      logic [7:0] color;
      logic       bold;
   } result_type;

   function automatic shadow_type apply_code(input logic [7:0] code, input shadow_type sh);
      shadow_type r;
      logic [7:0] off;
      r   = sh;
      off = 8'd0;
      if (code == SGR_RESET) begin
         r.fg      = FG_DEFAULT;
         r.bg      = BG_DEFAULT;
         r.bold    = 1'b0;
         r.touched = 1'b1;
      end else if (code == SGR_BOLD) begin
         r.bold = 1'b1;
      end else if (code == SGR_NOBOLD) begin
         r.bold = 1'b0;
      end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
         off       = code - SGR_FG_LO;
         r.fg      = {sh.bold, off[2:0]};
         r.touched = 1'b1;
      end else if (code >= SGR_FGB_LO && code <= SGR_FGB_HI) begin
         off       = code - SGR_FGB_LO;
         r.fg      = {1'b1, off[2:0]};
         r.touched = 1'b1;
      end else if (code == SGR_FG_DEF) begin
         r.fg      = FG_DEFAULT;
         r.touched = 1'b1;
      end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
         off  = code - SGR_BG_LO;
         r.bg = {1'b0, off[2:0]};
      end else if (code >= SGR_BGB_LO && code <= SGR_BGB_HI) begin
         off  = code - SGR_BGB_LO;
         r.bg = {1'b1, off[2:0]};
      end else if (code == SGR_BG_DEF) begin
         r.bg = BG_DEFAULT;
      end
      return r;
   endfunction

endpackage

>>> sv/sgr_step.sv
// ----------------------------------------------------------------------------
// sgr_step
// Next-state and result logic for one text byte of the SGR parser.
// ----------------------------------------------------------------------------
module sgr_step (
   input  sgr_pkg::parse_state_type cur,
   input  logic [7:0]               in_byte,
   output sgr_pkg::parse_state_type nxt,
   output sgr_pkg::result_type      res
);

   sgr_pkg::shadow_type sh_end;
   logic [3:0]          count_end;
   logic [7:0]          field_code;
   logic [11:0]         num_wide;
   logic [7:0]          digit;
   logic [3:0]          fg_commit;
   logic                is_digit;

   // close the current field: apply it if still within the code limit
   always_comb begin
      field_code = cur.present ? cur.num : 8'd0;
      if (32'(cur.count) < sgr_pkg::MAX_CODES) begin
         sh_end    = sgr_pkg::apply_code(field_code, cur.sh);
         count_end = cur.count + 4'd1;
      end else begin
         sh_end    = cur.sh;
         count_end = cur.count;
      end
   end

   // decimal accumulate with saturation at 255
   always_comb begin
      digit    = in_byte - sgr_pkg::CH_ZERO;
      num_wide = {1'b0, cur.num, 3'b000} + {3'b000, cur.num, 1'b0} + {4'd0, digit};
      is_digit = (in_byte >= sgr_pkg::CH_ZERO) && (in_byte <= sgr_pkg::CH_NINE);
   end

   // brighten an untouched dark foreground when bold commits
   always_comb begin
      fg_commit = sh_end.fg;
      if (sh_end.bold && !sh_end.touched && !sh_end.fg[3]) begin
         fg_commit = sh_end.fg + 4'd8;
      end
   end

   always_comb begin
      nxt          = cur;
      res.consumed = 1'b0;
      res.applied  = 1'b0;
      res.aborted  = 1'b0;
      unique case (cur.phase)
         sgr_pkg::PH_ESC: begin
            if (in_byte == sgr_pkg::CH_LBRK) begin
               nxt.phase      = sgr_pkg::PH_PARAM;
               nxt.sh.fg      = cur.color[3:0];
               nxt.sh.bg      = cur.color[7:4];
               nxt.sh.bold    = cur.bold;
               nxt.sh.touched = 1'b0;
               res.consumed   = 1'b1;
            end else if (in_byte == sgr_pkg::CH_ESC) begin
               res.aborted  = 1'b1;
               res.consumed = 1'b1;
               nxt.phase    = sgr_pkg::PH_ESC;
               nxt.num      = 8'd0;
               nxt.present  = 1'b0;
               nxt.count    = 4'd0;
            end else begin
               res.aborted = 1'b1;
               nxt.phase   = sgr_pkg::PH_IDLE;
            end
         end
         sgr_pkg::PH_PARAM: begin
            res.consumed = 1'b1;
            if (is_digit) begin
               nxt.num     = (num_wide > 12'd255) ? 8'd255 : num_wide[7:0];
               nxt.present = 1'b1;
            end else if (in_byte == sgr_pkg::CH_SEMI) begin
               nxt.sh      = sh_end;
               nxt.count   = count_end;
               nxt.num     = 8'd0;
               nxt.present = 1'b0;
            end else if (in_byte == sgr_pkg::CH_M) begin
               nxt.sh      = sh_end;
               nxt.count   = count_end;
               nxt.num     = 8'd0;
               nxt.present = 1'b0;
               nxt.color   = {sh_end.bg, fg_commit};
               nxt.bold    = sh_end.bold;
               nxt.phase   = sgr_pkg::PH_IDLE;
               res.applied = 1'b1;
            end else if (in_byte == sgr_pkg::CH_ESC) begin
               res.aborted = 1'b1;
               nxt.phase   = sgr_pkg::PH_ESC;
               nxt.num     = 8'd0;
               nxt.present = 1'b0;
               nxt.count   = 4'd0;
            end else begin
               res.consumed = 1'b0;
               res.aborted  = 1'b1;
               nxt.phase    = sgr_pkg::PH_IDLE;
            end
         end
         default: begin
            nxt.phase = sgr_pkg::PH_IDLE;
            if (in_byte == sgr_pkg::CH_ESC) begin
               res.consumed = 1'b1;
               nxt.phase    = sgr_pkg::PH_ESC;
               nxt.num      = 8'd0;
               nxt.present  = 1'b0;
               nxt.count    = 4'd0;
            end
         end
      endcase
      res.color = nxt.color;
      res.bold  = nxt.bold;
   end

endmodule

>>> sv/ansi_sgr_color_parser_core.sv
// ----------------------------------------------------------------------------
// ansi_sgr_color_parser_core
// Streaming ANSI SGR color parser: one text byte in, one status item out.
// ----------------------------------------------------------------------------
// Feed text bytes on the req_ channel. For every byte one item comes out on
// the rsp_ channel telling whether the byte was part of an escape sequence,
// whether it committed or broke one, and the VGA attribute and bold flag in
// force after it.
// The byte lands in an input register at the accepting edge, then one pass of
// decode logic updates the parser state and loads the result register that
// drives rsp_valid.
// Throughput is one byte per cycle while the receiver takes results; the limit
// is the single state update per byte in the decode pass.
// When the receiver stalls, the result register holds and the input register
// fills; req_ready drops only once both are occupied, and opens again in the
// same cycle the result is taken.
// Reset empties both registers, returns the parser to idle and sets the
// attribute to light grey on black with bold off.
// ----------------------------------------------------------------------------
module ansi_sgr_color_parser_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_byte_consumed,
   output logic       rsp_seq_applied,
   output logic       rsp_seq_aborted,
   output logic [7:0] rsp_attr_color,
   output logic       rsp_bold_flag
);

   logic                     in_valid_ff;
   logic [7:0]               in_byte_ff;
   logic                     out_valid_ff;
   sgr_pkg::result_type      out_ff;
   sgr_pkg::parse_state_type state_ff;
   sgr_pkg::parse_state_type state_in;
   sgr_pkg::result_type      res_in;
   logic                     advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   sgr_step u_step (
      .cur     (state_ff),
      .in_byte (in_byte_ff),
      .nxt     (state_in),
      .res     (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase   <= sgr_pkg::PH_IDLE;
         state_ff.num     <= 8'd0;
         state_ff.present <= 1'b0;
         state_ff.count   <= 4'd0;
         state_ff.sh      <= '0;
         state_ff.color   <= sgr_pkg::COLOR_RESET;
         state_ff.bold    <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= res_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_byte_consumed = out_ff.consumed;
   assign rsp_seq_applied   = out_ff.applied;
   assign rsp_seq_aborted   = out_ff.aborted;
   assign rsp_attr_color    = out_ff.color;
   assign rsp_bold_flag     = out_ff.bold;

   // commit and abort are exclusive, and a commit always eats its byte
   a_commit_abort: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_seq_applied && rsp_seq_aborted))
      else $error("commit and abort in the same item");

   a_commit_consumed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_seq_applied) |-> rsp_byte_consumed)
      else $error("committed item did not consume its byte");

   // parser state must hold while the result is stalled
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> $stable(state_ff))
      else $error("parser state moved during a stall");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      32'(state_ff.count) <= sgr_pkg::MAX_CODES)
      else $error("code count past limit");

endmodule
